// ===== sv/vrrb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrb_pkg
// Shared types and constants of the variable-length record ring buffer.
// ----------------------------------------------------------------------------
package vrrb_pkg;

  localparam int unsigned DEPTH_WORDS_DEF = 4096;
  localparam int unsigned MAX_PAYLOAD_DEF = 62;

  localparam int unsigned LW          = 6;
  localparam int unsigned CW          = 12;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned WORD_W      = 64;
  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 120;

  localparam logic [CW-1:0] COUNT_CAP = 12'd2048;
  localparam logic [WORD_W-1:0] MARK_WORD = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_WR_HDR  = 2'd0,
    OP_WR_WORD = 2'd1,
    OP_PEEK    = 2'd2,
    OP_POP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_OK     = 3'd0,
    STAT_EMPTY  = 3'd1,
    STAT_SHORT  = 3'd2,
    STAT_WOPEN  = 3'd3,
    STAT_TOOBIG = 3'd4
  } status_e;

  typedef struct packed {
    logic    wr_hdr;
    logic    wr_beat;
    logic    rd_head;
    logic    rd_zero;
    logic    stat_set;
    status_e stat_code;
    logic    resp_load;
    logic    hdr_load;
    logic    pay_load;
    logic    at_zero;
    logic    pop;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic head_ok;
    logic head_wrap;
    logic zero_ok;
    logic len_zero;
    logic pay_last;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/variable_record_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_record_ring_buffer
// Ring store of variable-length records: header word plus payload words.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the opcode (write header, write payload
// word, peek, pop); tdata carries stamp, payload length and the payload word.
// Output channel m_axis: one word per result; tuser flags the header/status
// word, tlast marks the final word caused by an input word.
// Write header and write payload words: one result each (memory write on
// accept, result loaded in S_RESP once the output is free). A header that
// needs a wrap marker writes the marker from mark_pend_q, set on accept.
// Peek/pop: the store's single read port with registered data sets the pace:
// the header word is read on accept and its result loaded from S_HDR (on a
// wrap, S_HDR reads address 0 and S_WRAP loads it), then one payload word per
// cycle while the output is free. Empty reads answer with one status word
// via S_RESP; short reads go from S_HDR or S_WRAP to S_RESP.
// Reset clears pointers, record count and write state; store contents stay
// undefined. A held output word stalls the sequencer until m_axis_tready; the
// input side takes the next word once the current item's last result is in
// the output register.
// ----------------------------------------------------------------------------
module variable_record_ring_buffer import vrrb_pkg::*; #(
  parameter int unsigned DEPTH_WORDS = DEPTH_WORDS_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // stamp[31:0], payload_words[37:32], word_in[101:38], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // status[2:0], stamp_out[34:3], length_out[40:35], word_out[104:41],
  // records_held[116:105], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // is_header[0]
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  cmd_t               cmd;
  sts_t               sts;
  status_e            status;
  logic [STAMP_W-1:0] stamp_out;
  logic [LW-1:0]      length_out;
  logic [WORD_W-1:0]  word_out;
  logic [CW-1:0]      records_held;

  vrrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vrrb_datapath #(
    .DEPTH_WORDS (DEPTH_WORDS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .stamp_i         (s_axis_tdata[31:0]),
    .payload_words_i (s_axis_tdata[37:32]),
    .word_in_i       (s_axis_tdata[101:38]),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .status_o        (status),
    .is_header_o     (m_axis_tuser),
    .stamp_out_o     (stamp_out),
    .length_out_o    (length_out),
    .word_out_o      (word_out),
    .last_o          (m_axis_tlast),
    .records_held_o  (records_held)
  );

  assign m_axis_tdata = {3'd0, records_held, word_out, length_out, stamp_out, status};

endmodule

// ===== sv/vrrb_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrb_ctrl
// Sequencer: takes input words, steps header lookup, wrap and payload readout.
// ----------------------------------------------------------------------------
module vrrb_ctrl import vrrb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RESP = 5'b00010,
    S_HDR  = 5'b00100,
    S_WRAP = 5'b01000,
    S_PAY  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   pop_q, pop_d;

  always_comb begin
    cmd_o         = '0;
    cmd_o.pop     = pop_q;
    cmd_o.at_zero = (state_q == S_WRAP);
    state_d       = state_q;
    pop_d         = pop_q;
    in_ready_o    = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (op_e'(opcode_i))
            OP_WR_HDR: begin
              cmd_o.wr_hdr = 1'b1;
              state_d      = S_RESP;
            end
            OP_WR_WORD: begin
              cmd_o.wr_beat = 1'b1;
              state_d       = S_RESP;
            end
            OP_PEEK, OP_POP: begin
              pop_d = (op_e'(opcode_i) == OP_POP);
              if (sts_i.count_zero) begin
                cmd_o.stat_set  = 1'b1;
                cmd_o.stat_code = STAT_EMPTY;
                state_d         = S_RESP;
              end else begin
                cmd_o.rd_head = 1'b1;
                state_d       = S_HDR;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.resp_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_HDR: begin
        priority if (sts_i.head_wrap) begin
          cmd_o.rd_zero = 1'b1;
          state_d       = S_WRAP;
        end else if (!sts_i.head_ok) begin
          cmd_o.stat_set  = 1'b1;
          cmd_o.stat_code = STAT_SHORT;
          state_d         = S_RESP;
        end else if (sts_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          state_d        = sts_i.len_zero ? S_IDLE : S_PAY;
        end
      end
      S_WRAP: begin
        priority if (!sts_i.zero_ok) begin
          cmd_o.stat_set  = 1'b1;
          cmd_o.stat_code = STAT_SHORT;
          state_d         = S_RESP;
        end else if (sts_i.out_free) begin
          cmd_o.hdr_load = 1'b1;
          state_d        = sts_i.len_zero ? S_IDLE : S_PAY;
        end
      end
      S_PAY: begin
        if (sts_i.out_free) begin
          cmd_o.pay_load = 1'b1;
          if (sts_i.pay_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pop_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pop_q   <= pop_d;
    end
  end

endmodule

// ===== sv/vrrb_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrrb_datapath
// Record store, ring pointers, write bookkeeping and the output register.
// ----------------------------------------------------------------------------
module vrrb_datapath import vrrb_pkg::*; #(
  parameter int unsigned DEPTH_WORDS = DEPTH_WORDS_DEF,
  parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic [STAMP_W-1:0] stamp_i,
  input  logic [LW-1:0]      payload_words_i,
  input  logic [WORD_W-1:0]  word_in_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output status_e            status_o,
  output logic               is_header_o,
  output logic [STAMP_W-1:0] stamp_out_o,
  output logic [LW-1:0]      length_out_o,
  output logic [WORD_W-1:0]  word_out_o,
  output logic               last_o,
  output logic [CW-1:0]      records_held_o
);

  localparam int unsigned AW = $clog2(DEPTH_WORDS);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned XW = PW + 1;
  localparam logic [XW-1:0] DepthX = XW'(DEPTH_WORDS);
  localparam logic [LW-1:0] MaxLen = LW'(MAX_PAYLOAD);

  logic [WORD_W-1:0] mem_q [DEPTH_WORDS];
  logic [WORD_W-1:0] rdata_q;

  logic [PW-1:0] head_q, rear_q;
  logic [CW-1:0] count_q;
  logic          wopen_q, wacc_q;
  logic [AW-1:0] waddr_q;
  logic [LW-1:0] beats_q;
  logic          mark_pend_q;
  logic [AW-1:0] mark_addr_q;
  logic [AW-1:0] pay_addr_q;
  logic [LW-1:0] pay_left_q;
  status_e       status_q;
  logic          out_valid_q;

  logic [XW-1:0] head_x, rear_x;
  logic          out_free;

  assign head_x   = XW'(head_q);
  assign rear_x   = XW'(rear_q);
  assign out_free = !out_valid_q || out_ready_i;

  // write header checks
  logic [XW-1:0] wh_size;
  logic          wh_too_big, wh_full, wh_go, wh_ok, wh_mark;
  logic [PW-1:0] wh_at;
  status_e       wh_stat;

  assign wh_size    = XW'(payload_words_i) + XW'(1);
  assign wh_too_big = (payload_words_i > MaxLen) || (wh_size >= DepthX);
  assign wh_full    = (rear_q == head_q) && (count_q != '0);
  assign wh_go      = !wopen_q && !wh_too_big && (count_q < COUNT_CAP);

  always_comb begin
    wh_ok   = 1'b0;
    wh_mark = 1'b0;
    wh_at   = '0;
    if (!wh_full) begin
      if (rear_q >= head_q) begin
        if ((rear_x <= DepthX) && (wh_size <= DepthX - rear_x)) begin
          wh_ok = 1'b1;
          wh_at = rear_q;
        end else begin
          wh_mark = 1'b1;
          if (wh_size <= head_x) begin
            wh_ok = 1'b1;
          end
        end
      end else if (rear_x + wh_size <= head_x) begin
        wh_ok = 1'b1;
        wh_at = rear_q;
      end
    end
  end

  always_comb begin
    priority if (wopen_q) begin
      wh_stat = STAT_WOPEN;
    end else if (wh_too_big) begin
      wh_stat = STAT_TOOBIG;
    end else if (count_q >= COUNT_CAP) begin
      wh_stat = STAT_SHORT;
    end else if (!wh_ok) begin
      wh_stat = STAT_SHORT;
    end else begin
      wh_stat = STAT_OK;
    end
  end

  logic hdr_commit, beat_store, beat_done;
  assign hdr_commit = cmd_i.wr_hdr && wh_go && wh_ok;
  assign beat_store = cmd_i.wr_beat && wopen_q && wacc_q;
  assign beat_done  = cmd_i.wr_beat && wopen_q && (beats_q == LW'(1));

  // stored header decode
  logic [LW-1:0] h_len;
  logic          h_mark;
  logic [XW-1:0] h_size;
  logic [PW-1:0] at_sel, at_next;

  assign h_mark  = rdata_q[WORD_W-1];
  assign h_len   = (rdata_q[37:32] > MaxLen) ? MaxLen : rdata_q[37:32];
  assign h_size  = XW'(h_len) + XW'(1);
  assign at_sel  = cmd_i.at_zero ? '0 : head_q;
  assign at_next = at_sel + PW'(h_len) + PW'(1);

  always_comb begin
    sts_o            = '0;
    sts_o.count_zero = (count_q == '0);
    sts_o.len_zero   = (h_len == '0);
    sts_o.pay_last   = (pay_left_q == LW'(1));
    sts_o.out_free   = out_free;
    sts_o.zero_ok    = (rear_x >= h_size) && !h_mark;
    if (rear_q > head_q) begin
      sts_o.head_ok = ((rear_x - head_x) >= h_size) && !h_mark;
    end else if ((head_x < DepthX) && !h_mark && (DepthX - head_x >= h_size)) begin
      sts_o.head_ok = 1'b1;
    end else begin
      sts_o.head_wrap = 1'b1;
    end
  end

  // memory ports
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_wa, mem_ra;
  logic [WORD_W-1:0] mem_wd;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    priority if (mark_pend_q) begin
      mem_we = 1'b1;
      mem_wa = mark_addr_q;
      mem_wd = MARK_WORD;
    end else if (hdr_commit) begin
      mem_we = 1'b1;
      mem_wa = wh_at[AW-1:0];
      mem_wd = {26'd0, payload_words_i, stamp_i};
    end else if (beat_store) begin
      mem_we = 1'b1;
      mem_wa = waddr_q;
      mem_wd = word_in_i;
    end
  end

  always_comb begin
    mem_re = 1'b0;
    mem_ra = '0;
    priority if (cmd_i.rd_head) begin
      mem_re = 1'b1;
      mem_ra = head_q[AW-1:0];
    end else if (cmd_i.rd_zero) begin
      mem_re = 1'b1;
    end else if (cmd_i.hdr_load && (h_len != '0)) begin
      mem_re = 1'b1;
      mem_ra = at_sel[AW-1:0] + AW'(1);
    end else if (cmd_i.pay_load && (pay_left_q > LW'(1))) begin
      mem_re = 1'b1;
      mem_ra = pay_addr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      rear_q      <= '0;
      count_q     <= '0;
      wopen_q     <= 1'b0;
      wacc_q      <= 1'b0;
      waddr_q     <= '0;
      beats_q     <= '0;
      mark_pend_q <= 1'b0;
      pay_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mark_pend_q <= cmd_i.wr_hdr && wh_go && wh_mark && (rear_x < DepthX);
      if (cmd_i.wr_hdr && !wopen_q) begin
        wopen_q <= (payload_words_i != '0);
        wacc_q  <= wh_go && wh_ok;
        beats_q <= payload_words_i;
        if (hdr_commit) begin
          rear_q  <= wh_at + PW'(payload_words_i) + PW'(1);
          waddr_q <= wh_at[AW-1:0] + AW'(1);
        end
      end
      if (cmd_i.wr_beat && wopen_q) begin
        if (wacc_q) begin
          waddr_q <= waddr_q + AW'(1);
        end
        beats_q <= beats_q - LW'(1);
        if (beats_q == LW'(1)) begin
          wopen_q <= 1'b0;
          wacc_q  <= 1'b0;
        end
      end
      if ((hdr_commit && (payload_words_i == '0)) || (beat_done && wacc_q)) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.hdr_load && cmd_i.pop) begin
        count_q <= count_q - CW'(1);
      end
      if (cmd_i.hdr_load && cmd_i.pop) begin
        head_q <= at_next;
      end
      if (cmd_i.hdr_load) begin
        pay_left_q <= h_len;
      end else if (cmd_i.pay_load) begin
        pay_left_q <= pay_left_q - LW'(1);
      end
      if (cmd_i.resp_load || cmd_i.hdr_load || cmd_i.pay_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_hdr) begin
      mark_addr_q <= rear_q[AW-1:0];
      status_q    <= wh_stat;
    end else if (cmd_i.wr_beat) begin
      status_q <= (wopen_q && wacc_q) ? STAT_OK : STAT_SHORT;
    end else if (cmd_i.stat_set) begin
      status_q <= cmd_i.stat_code;
    end
    if (cmd_i.hdr_load) begin
      pay_addr_q <= at_sel[AW-1:0] + AW'(2);
    end else if (cmd_i.pay_load) begin
      pay_addr_q <= pay_addr_q + AW'(1);
    end
    if (cmd_i.resp_load) begin
      status_o       <= status_q;
      is_header_o    <= 1'b1;
      stamp_out_o    <= '0;
      length_out_o   <= '0;
      word_out_o     <= '0;
      last_o         <= 1'b1;
      records_held_o <= count_q;
    end else if (cmd_i.hdr_load) begin
      status_o       <= STAT_OK;
      is_header_o    <= 1'b1;
      stamp_out_o    <= rdata_q[STAMP_W-1:0];
      length_out_o   <= h_len;
      word_out_o     <= '0;
      last_o         <= (h_len == '0);
      records_held_o <= cmd_i.pop ? (count_q - CW'(1)) : count_q;
    end else if (cmd_i.pay_load) begin
      status_o       <= STAT_OK;
      is_header_o    <= 1'b0;
      stamp_out_o    <= '0;
      length_out_o   <= '0;
      word_out_o     <= rdata_q;
      last_o         <= (pay_left_q == LW'(1));
      records_held_o <= count_q;
    end
  end

  assign out_valid_o = out_valid_q;

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= COUNT_CAP)
    else $error("record count above cap");

  a_open_beats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wopen_q |-> (beats_q != '0))
    else $error("open write with no beats left");

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rear_x <= DepthX) && (head_x <= DepthX))
    else $error("ring pointer beyond store");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.resp_load || cmd_i.hdr_load || cmd_i.pay_load) |-> out_free)
    else $error("output register overwritten while held");

  a_mark_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_pend_q |=> !mark_pend_q)
    else $error("wrap marker write pending twice");

endmodule

// ===== verif/tb_variable_record_ring_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_variable_record_ring_buffer
// Self-checking bench for the variable-length record ring buffer. A directed
// table covers empty reads, stray and dropped payload words, headers while a
// write is open, oversized headers and the largest records. The random part
// alternates fill rounds, which end on a header refused for lack of room, at
// the record cap or after a share of the word budget, with drain rounds.
// Every accepted input word is run through an in-bench ring predictor, and
// each output word is checked against the oldest predicted word. Sender
// bursts/gaps and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_variable_record_ring_buffer;
  import vrrb_pkg::*;

  localparam int unsigned DEPTH       = DEPTH_WORDS_DEF;
  localparam int unsigned MAXP        = MAX_PAYLOAD_DEF;
  localparam int unsigned RAND_ITEMS  = 240;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned MAX_SHOWN   = 40;
  localparam int unsigned N_ROWS      = 22;

  typedef struct packed {
    status_e             st;
    logic                hdr;
    logic [STAMP_W-1:0]  stamp;
    logic [LW-1:0]       len;
    logic [WORD_W-1:0]   word;
    logic                eor;
    logic [CW-1:0]       held;
  } ring_res_t;

  typedef struct {
    op_e                op;
    logic [STAMP_W-1:0] stamp;
    logic [LW-1:0]      plen;
    logic [WORD_W-1:0]  word;
    int unsigned        beats;
    bit                 pinned;
    status_e            pin_st;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [1:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;
  logic                   m_axis_tlast;

  variable_record_ring_buffer #(
    .DEPTH_WORDS(DEPTH),
    .MAX_PAYLOAD(MAXP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  // ring predictor state
  logic [WORD_W-1:0] ring_mem [DEPTH];
  int unsigned       ring_head;
  int unsigned       ring_rear;
  int unsigned       ring_held;
  int unsigned       wr_at;
  int unsigned       wr_left;
  bit                wr_open;
  bit                wr_taken;
  ring_res_t         due_words[$];

  int unsigned errors;
  int unsigned out_seen;
  int unsigned cycles;
  int unsigned burst_left;
  int unsigned rdy_run;

  // op, stamp, plen, word, beats after header, pinned, pinned status
  dir_row_t dir_rows [N_ROWS] = '{
    '{OP_PEEK,    32'h0,         6'd0,  64'h0,                  0,  1'b1, STAT_EMPTY},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b1, STAT_EMPTY},
    '{OP_WR_WORD, 32'h0,         6'd0,  64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b1, STAT_SHORT},
    '{OP_WR_HDR,  32'hFFFF_FFFF, 6'd0,  64'h0,                  0,  1'b1, STAT_OK},
    '{OP_PEEK,    32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_WR_HDR,  32'h0,         6'd62, 64'h0,                  62, 1'b1, STAT_OK},
    '{OP_WR_HDR,  32'hA5A5_A5A5, 6'd2,  64'hFFFF_FFFF_FFFF_FFFF, 1, 1'b1, STAT_OK},
    '{OP_WR_HDR,  32'h5A5A_5A5A, 6'd9,  64'h0,                  0,  1'b1, STAT_WOPEN},
    '{OP_WR_WORD, 32'h0,         6'd0,  64'h0123_4567_89AB_CDEF, 0, 1'b1, STAT_OK},
    '{OP_WR_HDR,  32'h0000_0077, 6'd63, 64'h5555_5555_5555_5555, 63, 1'b1, STAT_TOOBIG},
    '{OP_WR_WORD, 32'h0,         6'd0,  64'hAAAA_AAAA_AAAA_AAAA, 0, 1'b1, STAT_SHORT},
    '{OP_PEEK,    32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b1, STAT_EMPTY},
    '{OP_WR_HDR,  32'h8000_0001, 6'd1,  64'h8000_0000_0000_0001, 1, 1'b1, STAT_OK},
    '{OP_PEEK,    32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK},
    '{OP_PEEK,    32'h0,         6'd0,  64'h0,                  0,  1'b1, STAT_EMPTY},
    '{OP_WR_HDR,  32'h1234_5678, 6'd21, 64'hF0F0_0F0F_3C3C_C3C3, 21, 1'b1, STAT_OK},
    '{OP_POP,     32'h0,         6'd0,  64'h0,                  0,  1'b0, STAT_OK}
  };

  // ---------------------------------------------------------------- predictor
  function automatic logic [WORD_W-1:0] ring_rd(int unsigned a);
    return (a < DEPTH) ? ring_mem[a] : '0;
  endfunction

  function automatic void ring_wr(int unsigned a, logic [WORD_W-1:0] v);
    if (a < DEPTH) ring_mem[a] = v;
  endfunction

  function automatic int unsigned stored_len(logic [WORD_W-1:0] h);
    int unsigned n;
    n = h[37:32];
    return (n > MAXP) ? MAXP : n;
  endfunction

  function automatic void owe(status_e st, logic hdr, logic [STAMP_W-1:0] stamp,
                              logic [LW-1:0] len, logic [WORD_W-1:0] word, logic eor);
    ring_res_t r;
    r.st    = st;
    r.hdr   = hdr;
    r.stamp = stamp;
    r.len   = len;
    r.word  = word;
    r.eor   = eor;
    r.held  = ring_held[CW-1:0];
    due_words.push_back(r);
  endfunction

  function automatic status_e ring_put_header(logic [STAMP_W-1:0] stamp, int unsigned len);
    int unsigned size;
    int unsigned at;
    bit fits;
    size = len + 1;
    at   = 0;
    fits = 1'b0;
    if (wr_open) return STAT_WOPEN;
    wr_open  = (len > 0);
    wr_taken = 1'b0;
    wr_left  = len;
    if (len > MAXP || size >= DEPTH) return STAT_TOOBIG;
    if (ring_held >= COUNT_CAP) return STAT_SHORT;
    if (ring_rear == ring_head && ring_held > 0) begin
      fits = 1'b0;
    end else if (ring_rear >= ring_head) begin
      if (ring_rear <= DEPTH && size <= DEPTH - ring_rear) begin
        at   = ring_rear;
        fits = 1'b1;
      end else begin
        ring_wr(ring_rear, MARK_WORD);
        if (size <= ring_head) begin
          at   = 0;
          fits = 1'b1;
        end
      end
    end else if (ring_rear + size <= ring_head) begin
      at   = ring_rear;
      fits = 1'b1;
    end
    if (!fits) return STAT_SHORT;
    ring_wr(at, {26'd0, len[LW-1:0], stamp});
    ring_rear = at + size;
    wr_at     = at + 1;
    wr_taken  = 1'b1;
    if (len == 0) ring_held++;
    return STAT_OK;
  endfunction

  function automatic status_e ring_put_word(logic [WORD_W-1:0] w);
    bit took;
    if (!wr_open) return STAT_SHORT;
    took = wr_taken;
    if (took) begin
      ring_wr(wr_at, w);
      wr_at++;
    end
    if (wr_left > 0) wr_left--;
    if (wr_left == 0) begin
      wr_open = 1'b0;
      if (took) ring_held++;
      wr_taken = 1'b0;
    end
    return took ? STAT_OK : STAT_SHORT;
  endfunction

  function automatic void ring_fetch(bit pop);
    int unsigned at;
    int unsigned len;
    int unsigned size;
    int unsigned i;
    logic [WORD_W-1:0] h;
    bit ok;
    at = ring_head;
    if (ring_held == 0) begin
      owe(STAT_EMPTY, 1'b1, '0, '0, '0, 1'b1);
      return;
    end
    h    = ring_rd(at);
    len  = stored_len(h);
    size = len + 1;
    if (ring_rear > ring_head) begin
      ok = (ring_rear - ring_head) >= size && !h[63];
    end else if (ring_head < DEPTH && !h[63] && DEPTH - ring_head >= size) begin
      ok = 1'b1;
    end else begin
      // marker or end of store: record restarts at address 0
      at   = 0;
      h    = ring_rd(0);
      len  = stored_len(h);
      size = len + 1;
      ok   = ring_rear >= size && !h[63];
    end
    if (!ok) begin
      owe(STAT_SHORT, 1'b1, '0, '0, '0, 1'b1);
      return;
    end
    if (pop) begin
      ring_head = at + size;
      ring_held--;
    end
    owe(STAT_OK, 1'b1, h[31:0], len[LW-1:0], '0, len == 0);
    for (i = 0; i < len; i++)
      owe(STAT_OK, 1'b0, '0, '0, ring_rd(at + 1 + i), i + 1 == len);
  endfunction

  function automatic status_e ring_apply(op_e op, logic [STAMP_W-1:0] stamp,
                                         logic [LW-1:0] plen, logic [WORD_W-1:0] word);
    status_e st;
    int unsigned mark;
    mark = due_words.size();
    case (op)
      OP_WR_HDR: begin
        st = ring_put_header(stamp, plen);
        owe(st, 1'b1, '0, '0, '0, 1'b1);
      end
      OP_WR_WORD: begin
        st = ring_put_word(word);
        owe(st, 1'b1, '0, '0, '0, 1'b1);
      end
      default: begin
        ring_fetch(op == OP_POP);
        st = due_words[mark].st;
      end
    endcase
    return st;
  endfunction

  // ---------------------------------------------------------------- stimulus
  task automatic send_word(input op_e op, input logic [STAMP_W-1:0] stamp,
                           input logic [LW-1:0] plen, input logic [WORD_W-1:0] word,
                           input bit pin, input status_e pin_st, output status_e st);
    int unsigned gap;
    int unsigned mark;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {2'b00, word, plen, stamp};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    mark = due_words.size();
    st   = ring_apply(op, stamp, plen, word);
    if (pin) due_words[mark].st = pin_st;
  endtask

  // header then its payload words; intrude puts a stray word mid-payload
  task automatic send_record(input logic [STAMP_W-1:0] stamp, input logic [LW-1:0] plen,
                             input int unsigned beats, input bit rnd,
                             input logic [WORD_W-1:0] w0, input bit pin,
                             input status_e pin_st, input bit intrude,
                             output status_e st);
    status_e dummy;
    logic [WORD_W-1:0] w;
    op_e cut;
    int unsigned k;
    send_word(OP_WR_HDR, stamp, plen, '0, pin, pin_st, st);
    for (k = 0; k < beats; k++) begin
      if (intrude && k == beats / 2) begin
        cut = op_e'($urandom_range(0, 3));
        if (cut == OP_WR_WORD) cut = OP_WR_HDR;
        send_word(cut, $urandom, LW'($urandom_range(0, 63)), '0, 1'b0, STAT_OK, dummy);
      end
      w = rnd ? {$urandom, $urandom} : (k[0] ? ~w0 : w0);
      send_word(OP_WR_WORD, '0, '0, w, 1'b0, STAT_OK, dummy);
    end
  endtask

  task automatic send_read(input op_e op);
    status_e dummy;
    send_word(op, $urandom, LW'($urandom_range(0, 63)), {$urandom, $urandom},
              1'b0, STAT_OK, dummy);
  endtask

  // hold the sender until every predicted word has come out
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (due_words.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic note_mismatch(input string msg);
    errors++;
    if (errors <= MAX_SHOWN) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------- clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** variable_record_ring_buffer: FAILED **");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk_i) begin
    if (rdy_run == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b1;
        rdy_run = $urandom_range(100, 400);
      end else if ($urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        rdy_run = $urandom_range(1, 6);
      end else begin
        m_axis_tready <= 1'b1;
        rdy_run = $urandom_range(1, 12);
      end
    end else begin
      rdy_run--;
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk_i) begin : check_out
    ring_res_t got;
    ring_res_t want;
    string diff;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.st    = status_e'(m_axis_tdata[2:0]);
      got.stamp = m_axis_tdata[34:3];
      got.len   = m_axis_tdata[40:35];
      got.word  = m_axis_tdata[104:41];
      got.held  = m_axis_tdata[116:105];
      got.hdr   = m_axis_tuser;
      got.eor   = m_axis_tlast;
      if (due_words.size() == 0) begin
        note_mismatch($sformatf("word %0d arrived with nothing due", out_seen));
      end else begin
        want = due_words.pop_front();
        diff = "";
        if (got.st !== want.st)
          diff = {diff, $sformatf(" status %0d/%0d", got.st, want.st)};
        if (got.hdr !== want.hdr)
          diff = {diff, $sformatf(" is_header %0b/%0b", got.hdr, want.hdr)};
        if (got.stamp !== want.stamp)
          diff = {diff, $sformatf(" stamp %h/%h", got.stamp, want.stamp)};
        if (got.len !== want.len)
          diff = {diff, $sformatf(" length %0d/%0d", got.len, want.len)};
        if (got.word !== want.word)
          diff = {diff, $sformatf(" word %h/%h", got.word, want.word)};
        if (got.eor !== want.eor)
          diff = {diff, $sformatf(" last %0b/%0b", got.eor, want.eor)};
        if (got.held !== want.held)
          diff = {diff, $sformatf(" held %0d/%0d", got.held, want.held)};
        if (m_axis_tdata[OUT_TDATA_W-1:117] !== '0)
          diff = {diff, " pad bits set"};
        if (diff != "") note_mismatch($sformatf("word %0d (got/exp):%s", out_seen, diff));
      end
      out_seen++;
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    status_e st;
    int unsigned i;
    int unsigned pick;
    int unsigned r;
    int unsigned len;
    int unsigned rand_items;
    int unsigned round_end;
    bit intr;
    bit full;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_WR_HDR;
    m_axis_tready = 1'b0;
    rst_ni        = 1'b0;
    errors        = 0;
    out_seen      = 0;
    cycles        = 0;
    burst_left    = 0;
    rdy_run       = 0;
    ring_head     = 0;
    ring_rear     = 0;
    ring_held     = 0;
    wr_at         = 0;
    wr_left       = 0;
    wr_open       = 1'b0;
    wr_taken      = 1'b0;
    foreach (ring_mem[j]) ring_mem[j] = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed table
    for (i = 0; i < N_ROWS; i++) begin
      if (dir_rows[i].op == OP_WR_HDR)
        send_record(dir_rows[i].stamp, dir_rows[i].plen, dir_rows[i].beats, 1'b0,
                    dir_rows[i].word, dir_rows[i].pinned, dir_rows[i].pin_st, 1'b0, st);
      else
        send_word(dir_rows[i].op, dir_rows[i].stamp, dir_rows[i].plen, dir_rows[i].word,
                  dir_rows[i].pinned, dir_rows[i].pin_st, st);
    end
    settle();

    // fill until no room or the round's share is used, then drain, in rounds
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      full      = 1'b0;
      round_end = rand_items + $urandom_range(30, 90);
      while (!full && rand_items < round_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          r = $urandom_range(0, 99);
          if (r < 10)      len = 0;
          else if (r < 22) len = $urandom_range(1, 3);
          else if (r < 32) len = $urandom_range(4, 29);
          else if (r < 80) len = $urandom_range(30, MAXP - 1);
          else if (r < 92) len = MAXP;
          else             len = MAXP + 1;
          intr = ($urandom_range(0, 19) == 0);
          send_record($urandom, len[LW-1:0], len, 1'b1, '0, 1'b0, STAT_OK, intr, st);
          rand_items += len + 1 + intr;
          if (st == STAT_SHORT || ring_held >= COUNT_CAP) full = 1'b1;
        end else if (pick < 86) begin
          send_read(OP_PEEK);
          rand_items++;
        end else if (pick < 94) begin
          send_read(OP_POP);
          rand_items++;
        end else begin
          send_word(OP_WR_WORD, $urandom, LW'($urandom_range(0, 63)), {$urandom, $urandom},
                    1'b0, STAT_OK, st);
          rand_items++;
        end
      end
      if ($urandom_range(0, 1) == 0) settle();
      do begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_read(OP_POP);
          rand_items++;
        end else if (pick < 92) begin
          send_read(OP_PEEK);
          rand_items++;
        end else if (pick < 97) begin
          len = $urandom_range(0, 3);
          send_record($urandom, len[LW-1:0], len, 1'b1, '0, 1'b0, STAT_OK, 1'b0, st);
          rand_items += len + 1;
        end else begin
          send_word(OP_WR_WORD, $urandom, LW'($urandom_range(0, 63)), {$urandom, $urandom},
                    1'b0, STAT_OK, st);
          rand_items++;
        end
      end while (ring_held != 0 && $urandom_range(0, 149) != 0);
      if ($urandom_range(0, 2) == 0) settle();
    end

    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && due_words.size() == 0) begin
      $display("** variable_record_ring_buffer: PASSED **");
    end else begin
      $display("** variable_record_ring_buffer: FAILED **");
    end
    $finish;
  end

endmodule
